### hdl/rzh_pkg.sv
// Shared types, codes and defaults for the RGB zone histogram.
`default_nettype none

package rzh_pkg;

    localparam int BIN_COUNT_DEF   = 256;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int COORD_WIDTH_DEF = 12;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int FUNC_W     = 2;
    localparam int COMP_W     = 8;
    localparam int OUT_W      = 32;

    localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ZONE_MIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_MIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_MAX_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_MAX_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_RST = 13'd4096;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_READ
    } state_t;

    // Per-lane memory control.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_clear;
    } lane_ctl_t;

    // Control toward the merging stage.
    typedef struct packed {
        logic inc_total;
        logic clr_total;
        logic load_out;
        logic oob;
    } merge_ctl_t;

endpackage

`default_nettype wire

### hdl/rzh_if.sv
// Valid/ready channel interfaces for pixel commands and bin read results.
`default_nettype none

interface rzh_in_if #(
    parameter int COORD_WIDTH = 12
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             func;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [7:0]             bin_index;

    modport source (
        output valid, func, pixel_x, pixel_y, red, green, blue, bin_index,
        input  ready
    );
    modport sink (
        input  valid, func, pixel_x, pixel_y, red, green, blue, bin_index,
        output ready
    );
endinterface

interface rzh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] red_count;
    logic [31:0] green_count;
    logic [31:0] blue_count;
    logic [31:0] sample_total;

    modport source (
        output valid, red_count, green_count, blue_count, sample_total,
        input  ready
    );
    modport sink (
        input  valid, red_count, green_count, blue_count, sample_total,
        output ready
    );
endinterface

`default_nettype wire

### hdl/rzh_lane.sv
// One color lane: bin memory with registered read and saturating write-back.
`default_nettype none

module rzh_lane #(
    parameter int BIN_COUNT   = 256,
    parameter int COUNT_WIDTH = 32,
    localparam int BIN_W      = $clog2(BIN_COUNT)
) (
    input  wire logic                   clk,
    input  wire rzh_pkg::lane_ctl_t     ctl,
    input  wire logic [BIN_W-1:0]       addr,
    output logic      [COUNT_WIDTH-1:0] rd_data
);
    import rzh_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [BIN_W-1:0]       addr_reg;
    logic [BIN_W-1:0]       wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    // Except during a clear, the write-back goes to the bin read in the cycle before.
    assign wr_addr = ctl.wr_clear ? addr : addr_reg;
    assign wr_data = ctl.wr_clear ? '0 :
                     (&rd_data_reg) ? rd_data_reg :
                     COUNT_WIDTH'(rd_data_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
            addr_reg    <= addr;
        end
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/rzh_merge.sv
// Merging stage: sample total, 32-bit clamping and the result register.
`default_nettype none

module rzh_merge #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rzh_pkg::merge_ctl_t    ctl,
    input  wire logic [COUNT_WIDTH-1:0] red_data,
    input  wire logic [COUNT_WIDTH-1:0] green_data,
    input  wire logic [COUNT_WIDTH-1:0] blue_data,
    output logic                        slot_free,
    rzh_out_if.source                   out_ch
);
    import rzh_pkg::*;

    logic [COUNT_WIDTH-1:0]        total_reg;
    logic [COUNT_WIDTH-1:0]        total_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [3:0][COUNT_WIDTH-1:0]   raw;
    logic [3:0][OUT_W-1:0]         clamped;
    logic [OUT_W-1:0]              red_reg;
    logic [OUT_W-1:0]              green_reg;
    logic [OUT_W-1:0]              blue_reg;
    logic [OUT_W-1:0]              sum_reg;

    assign raw[0] = red_data;
    assign raw[1] = green_data;
    assign raw[2] = blue_data;
    assign raw[3] = total_reg;

    // Counts wider than the result fields read as all ones once they overflow them.
    for (genvar i = 0; i < 4; i++)
    begin : g_clamp
        if (COUNT_WIDTH > OUT_W)
        begin : g_wide
            assign clamped[i] = (|raw[i][COUNT_WIDTH-1:OUT_W]) ? '1 : raw[i][OUT_W-1:0];
        end
        else
        begin : g_narrow
            assign clamped[i] = OUT_W'(raw[i]);
        end
    end

    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        total_next = total_reg;
        if (ctl.clr_total)
        begin
            total_next = '0;
        end
        else if (ctl.inc_total && !(&total_reg))
        begin
            total_next = COUNT_WIDTH'(total_reg + 1'b1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            red_reg   <= ctl.oob ? '0 : clamped[0];
            green_reg <= ctl.oob ? '0 : clamped[1];
            blue_reg  <= ctl.oob ? '0 : clamped[2];
            sum_reg   <= clamped[3];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.red_count    = red_reg;
    assign out_ch.green_count  = green_reg;
    assign out_ch.blue_count   = blue_reg;
    assign out_ch.sample_total = sum_reg;

endmodule

`default_nettype wire

### hdl/rgb_zone_histogram_top.sv
// Top level: zone clipping, command sequencer and the three color lanes.
//
//  Channel   Dir  Payload                                        Transfer
//  cfg       in   cfg_index, cfg_data                            cfg_we high
//  in_ch     in   func, pixel_x, pixel_y, red, green, blue, bin  valid && ready
//  out_ch    out  red/green/blue_count, sample_total             valid && ready
//
// An accumulate whose pixel falls in the zone reads the bin, then writes it back
// through the lane memory port; one outside the zone returns straight to idle.
// A read fetches the bin, then waits for the result register to empty.
// A clear sweeps all BIN_COUNT bins, one bin per cycle in all three lanes.
// After reset the same sweep runs before the first transfer.
`default_nettype none

module rgb_zone_histogram_top #(
    parameter int BIN_COUNT   = rzh_pkg::BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = rzh_pkg::COUNT_WIDTH_DEF,
    parameter int COORD_WIDTH = rzh_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rzh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rzh_pkg::CFG_DATA_W-1:0] cfg_data,
    rzh_in_if.sink                              in_ch,
    rzh_out_if.source                           out_ch
);
    import rzh_pkg::*;

    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int IDX_W = ((BIN_W > COMP_W) ? BIN_W : COMP_W) + 1;
    localparam int CMP_W = (COORD_WIDTH > CFG_DATA_W) ? COORD_WIDTH : CFG_DATA_W;
    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BIN_COUNT - 1);

    logic [CFG_DATA_W-1:0] zone_min_x_reg;
    logic [CFG_DATA_W-1:0] zone_min_y_reg;
    logic [CFG_DATA_W-1:0] zone_max_x_reg;
    logic [CFG_DATA_W-1:0] zone_max_y_reg;
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;

    state_t           state_reg;
    state_t           state_next;
    logic [BIN_W-1:0] clr_cnt_reg;
    logic [BIN_W-1:0] clr_cnt_next;
    logic             oob_reg;
    logic             oob_next;

    logic             accept;
    logic             hit;
    logic             slot_free;
    logic [CMP_W-1:0] x0, y0, x1, y1, px, py;
    logic [BIN_W-1:0] red_bin, green_bin, blue_bin, read_bin;
    logic [BIN_W-1:0] red_addr, green_addr, blue_addr;
    lane_ctl_t        lane_ctl;
    merge_ctl_t       merge_ctl;
    logic [COUNT_WIDTH-1:0] red_data, green_data, blue_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_min_x_reg   <= '0;
            zone_min_y_reg   <= '0;
            zone_max_x_reg   <= '0;
            zone_max_y_reg   <= '0;
            frame_width_reg  <= FRAME_SIZE_RST;
            frame_height_reg <= FRAME_SIZE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZONE_MIN_X:   zone_min_x_reg   <= cfg_data;
                REG_ZONE_MIN_Y:   zone_min_y_reg   <= cfg_data;
                REG_ZONE_MAX_X:   zone_max_x_reg   <= cfg_data;
                REG_ZONE_MAX_Y:   zone_max_y_reg   <= cfg_data;
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Zone clipping: negative minima become zero, maxima stop at the frame size.
    assign x0 = zone_min_x_reg[CFG_DATA_W-1] ? '0 : CMP_W'(zone_min_x_reg);
    assign y0 = zone_min_y_reg[CFG_DATA_W-1] ? '0 : CMP_W'(zone_min_y_reg);
    assign x1 = (zone_max_x_reg >= frame_width_reg) ? CMP_W'(frame_width_reg)
                                                    : CMP_W'(zone_max_x_reg);
    assign y1 = (zone_max_y_reg >= frame_height_reg) ? CMP_W'(frame_height_reg)
                                                     : CMP_W'(zone_max_y_reg);
    assign px = CMP_W'(in_ch.pixel_x);
    assign py = CMP_W'(in_ch.pixel_y);

    assign hit = (zone_max_y_reg != '0) && (px >= x0) && (px < x1)
              && (py >= y0) && (py < y1);

    // Components past the last bin land in the last bin.
    assign red_bin   = (IDX_W'(in_ch.red) >= IDX_W'(BIN_COUNT)) ? BIN_LAST
                                                                : BIN_W'(in_ch.red);
    assign green_bin = (IDX_W'(in_ch.green) >= IDX_W'(BIN_COUNT)) ? BIN_LAST
                                                                  : BIN_W'(in_ch.green);
    assign blue_bin  = (IDX_W'(in_ch.blue) >= IDX_W'(BIN_COUNT)) ? BIN_LAST
                                                                 : BIN_W'(in_ch.blue);
    assign read_bin  = BIN_W'(in_ch.bin_index);

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == BIN_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.func)
                        FUNC_ACCUM: state_next = hit ? ST_ACC : ST_IDLE;
                        FUNC_READ:  state_next = ST_READ;
                        FUNC_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACC:
            begin
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        lane_ctl.rd_en    = accept && (((in_ch.func == FUNC_ACCUM) && hit)
                                       || (in_ch.func == FUNC_READ));
        lane_ctl.wr_en    = (state_reg == ST_ACC) || (state_reg == ST_CLEAR);
        lane_ctl.wr_clear = (state_reg == ST_CLEAR);

        merge_ctl.inc_total = (state_reg == ST_ACC);
        merge_ctl.clr_total = (state_reg == ST_CLEAR);
        merge_ctl.load_out  = (state_reg == ST_READ) && slot_free;
        merge_ctl.oob       = oob_reg;

        clr_cnt_next = (state_reg == ST_CLEAR) ? BIN_W'(clr_cnt_reg + 1'b1) : '0;
        oob_next     = accept ? (IDX_W'(in_ch.bin_index) >= IDX_W'(BIN_COUNT)) : oob_reg;

        if (state_reg == ST_CLEAR)
        begin
            red_addr   = clr_cnt_reg;
            green_addr = clr_cnt_reg;
            blue_addr  = clr_cnt_reg;
        end
        else if (in_ch.func == FUNC_READ)
        begin
            red_addr   = read_bin;
            green_addr = read_bin;
            blue_addr  = read_bin;
        end
        else
        begin
            red_addr   = red_bin;
            green_addr = green_bin;
            blue_addr  = blue_bin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            oob_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            oob_reg     <= oob_next;
        end
    end

    rzh_lane #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane_red (
        .clk     (clk),
        .ctl     (lane_ctl),
        .addr    (red_addr),
        .rd_data (red_data)
    );

    rzh_lane #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane_green (
        .clk     (clk),
        .ctl     (lane_ctl),
        .addr    (green_addr),
        .rd_data (green_data)
    );

    rzh_lane #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane_blue (
        .clk     (clk),
        .ctl     (lane_ctl),
        .addr    (blue_addr),
        .rd_data (blue_data)
    );

    rzh_merge #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (merge_ctl),
        .red_data   (red_data),
        .green_data (green_data),
        .blue_data  (blue_data),
        .slot_free  (slot_free),
        .out_ch     (out_ch)
    );

    a_read_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_ch.func == FUNC_READ) |=> state_reg == ST_READ)
        else $error("read transfer did not enter the result wait");

    a_clear_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) && (clr_cnt_reg != BIN_LAST) |=> state_reg == ST_CLEAR)
        else $error("clear sweep ended early");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(state_reg == ST_READ))
        else $error("result appeared without a read");

    a_writeback_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACC |-> $past(lane_ctl.rd_en))
        else $error("bin write-back without a preceding bin read");

endmodule

`default_nettype wire
